[design/itrd_pkg.sv]
// Shared constants, types and a helper function for the radix digit converter.
package itrd_pkg;

  // Default width of the converted value.
  localparam int VALUE_WIDTH_DEF = 32;

  // Radix limits and the one radix that shows a sign.
  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] DEC_RADIX = 6'd10;

  // Character codes.
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_NONE  = 7'h00;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Map a digit value of 0 to 35 onto its ASCII character.
  function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
    logic [6:0] d7;
    d7 = {1'b0, d};
    if (d > 6'd9) begin
      digit_to_ascii = d7 - 7'd10 + CHAR_A;
    end else begin
      digit_to_ascii = d7 + CHAR_ZERO;
    end
  endfunction

endpackage

[design/itrd_divider.sv]
// Iterative restoring divider: one quotient bit per cycle by a 6-bit radix.
module itrd_divider #(
  parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [VALUE_WIDTH-1:0]   dividend,
  input  logic [5:0]               divisor,
  output itrd_pkg::div_status_t    status,
  output logic [VALUE_WIDTH-1:0]   quotient,
  output logic [5:0]               remainder
);
  import itrd_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quo;
  logic [5:0]             rem;
  logic [5:0]             dvs;
  logic [CNT_W-1:0]       count;
  logic                   busy;
  logic                   done;
  logic [6:0]             trial;
  logic                   fits;

  // One shift-and-subtract step on the partial remainder.
  assign trial = {rem, quo[VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Control: a run of VALUE_WIDTH steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(VALUE_WIDTH);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= 6'(trial - {1'b0, dvs});
        quo <= {quo[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial[5:0];
        quo <= {quo[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;
  assign remainder   = rem;

endmodule

[design/integer_to_radix_digits_core.sv]
// Top level: converts one value into ASCII digits in a chosen radix, most significant first.
// Each digit comes from the shared bit-serial divider and goes, least significant first, into
// a buffer memory; each character is then read back from the buffer and shown. A new request
// is taken only after the last character of the current one, and a bad radix gives a single
// error character. Reset is synchronous, active high, and idles the sequencer.
module integer_to_radix_digits_core #(
  parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   action,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [5:0]             base,
  output logic                   char_valid,
  input  logic                   char_stall,
  output logic [6:0]             digit_char,
  output logic                   last,
  output logic                   bad_base
);
  import itrd_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W = $clog2(VALUE_WIDTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIVIDE = 6'b000010,
    S_SIGN   = 6'b000100,
    S_READ   = 6'b001000,
    S_SHOW   = 6'b010000,
    S_ERROR  = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             neg, neg_next;
  logic [5:0]       base_q;

  logic             accept;
  logic             char_take;
  logic             base_bad;
  logic             in_neg;
  logic [VALUE_WIDTH-1:0] magnitude;

  logic             div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [5:0]       div_divisor;
  div_status_t      div_stat;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [5:0]       div_rem;

  logic             mem_we;
  logic [6:0]       mem_wdata;
  logic [6:0]       mem [VALUE_WIDTH];
  logic [6:0]       rd_q;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign char_take  = char_valid && !char_stall;

  // Request decode: radix check, sign handling and magnitude.
  assign base_bad  = (base < RADIX_MIN) || (base > RADIX_MAX);
  assign in_neg    = !action && (base == DEC_RADIX) && value[VALUE_WIDTH-1];
  assign magnitude = in_neg ? (~value + 1'b1) : value;

  // Divider feed: the first step divides the magnitude, later ones the last quotient.
  assign div_dividend = accept ? magnitude : div_quo;
  assign div_divisor  = accept ? base : base_q;

  itrd_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_stat),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    neg_next   = neg;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    mem_wdata  = digit_to_ascii(div_rem);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          neg_next = in_neg;
          cnt_next = '0;
          if (base_bad) begin
            state_next = S_ERROR;
          end else if (magnitude == '0) begin
            mem_we     = 1'b1;
            mem_wdata  = CHAR_ZERO;
            cnt_next   = CNT_W'(1);
            state_next = S_READ;
          end else begin
            div_start  = 1'b1;
            state_next = S_DIVIDE;
          end
        end
      end
      S_DIVIDE: begin
        if (div_stat.done) begin
          mem_we   = 1'b1;
          cnt_next = cnt + 1'b1;
          if (div_quo == '0) begin
            state_next = neg ? S_SIGN : S_READ;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (char_take) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cnt_next   = cnt - 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (char_take) begin
          state_next = (cnt == '0) ? S_IDLE : S_READ;
        end
      end
      S_ERROR: begin
        if (char_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      neg   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      neg   <= neg_next;
    end
  end

  // The radix is held for the later divisions.
  always_ff @(posedge clk) begin
    if (accept) begin
      base_q <= base;
    end
  end

  // Digit buffer: written least significant first, read back in reverse.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt[IDX_W-1:0]] <= mem_wdata;
    end
    if (state == S_READ) begin
      rd_q <= mem[cnt_next[IDX_W-1:0]];
    end
  end

  // Result outputs.
  assign char_valid = (state == S_SIGN) || (state == S_SHOW) || (state == S_ERROR);
  assign bad_base   = (state == S_ERROR);
  assign last       = (state == S_ERROR) || ((state == S_SHOW) && (cnt == '0));
  assign digit_char = (state == S_SIGN)  ? CHAR_MINUS :
                      (state == S_ERROR) ? CHAR_NONE  : rd_q;

`ifndef ASSERT_OFF
  // An error request carries no character and ends the conversion.
  assert property (@(posedge clk) disable iff (rst)
    char_valid && bad_base |-> last && (digit_char == CHAR_NONE))
    else $error("bad radix result without last or with a character");

  // The digit count never outgrows the buffer.
  assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(VALUE_WIDTH))
    else $error("digit count beyond buffer depth");

  // The divider reports completion only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIVIDE))
    else $error("divider done outside the divide state");

  // A taken minus sign is always followed by digits.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SIGN) && !char_stall |=> (state == S_READ) && (cnt != '0))
    else $error("minus sign not followed by digits");
`endif

endmodule

[dv/integer_to_radix_digits_core_tb.sv]
// Testbench for integer_to_radix_digits_core: directed table and predicted random requests.
module integer_to_radix_digits_core_tb;
  import itrd_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam int RANDOM_REQUESTS = 360;
  localparam int IDLE_LIMIT = 10000;
  localparam int DRAIN_CYCLES = 1200;

  // Conversion modes carried by the action field.
  localparam logic ACT_SIGNED   = 1'b0;
  localparam logic ACT_UNSIGNED = 1'b1;

  // How the expected characters of a directed row are obtained.
  typedef enum logic [1:0] {ROW_PREDICTED, ROW_TEXT, ROW_ERROR} row_kind_e;

  // Receiver stall patterns.
  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_SOLID} stall_mode_e;

  // One emitted character with its flags.
  typedef struct packed {
    logic [6:0] digit_char;
    logic       last;
    logic       bad_base;
  } char_rec_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          item_valid = 1'b0;
  logic          item_stall;
  logic          action = 1'b0;
  logic [VW-1:0] value = '0;
  logic [5:0]    base = '0;
  logic          char_valid;
  logic          char_stall = 1'b0;
  logic [6:0]    digit_char;
  logic          last;
  logic          bad_base;

  char_rec_t     pending_chars[$];
  int            mismatches = 0;
  int            burst_left = 0;
  stall_mode_e   stall_mode = STALL_NONE;
  int            stall_left = 0;

  // Directed stimulus table.
  logic          dir_act[$];
  logic [VW-1:0] dir_val[$];
  logic [5:0]    dir_base[$];
  row_kind_e     dir_kind[$];
  string         dir_text[$];

  integer_to_radix_digits_core #(
    .VALUE_WIDTH(VW)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .action(action),
    .value(value),
    .base(base),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .digit_char(digit_char),
    .last(last),
    .bad_base(bad_base)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Work out the characters a request produces and queue them.
  task automatic predict_digits(input logic act, input logic [VW-1:0] val, input logic [5:0] b);
    char_rec_t    rec;
    logic [6:0]   digs[$];
    logic [VW-1:0] mag;
    logic         neg;
    logic [5:0]   d;
    if (b < RADIX_MIN || b > RADIX_MAX) begin
      rec = '{digit_char: CHAR_NONE, last: 1'b1, bad_base: 1'b1};
      pending_chars.push_back(rec);
      return;
    end
    // Only decimal signed conversion shows a sign; the most negative value keeps its magnitude.
    neg = (act == ACT_SIGNED) && (b == DEC_RADIX) && val[VW-1];
    mag = neg ? -val : val;
    if (mag == '0) begin
      digs.push_back(CHAR_ZERO);
    end
    while (mag != '0) begin
      d = 6'(mag % VW'(b));
      mag = mag / VW'(b);
      digs.push_front((d > 6'd9) ? CHAR_A + 7'(d) - 7'd10 : CHAR_ZERO + 7'(d));
    end
    if (neg) begin
      rec = '{digit_char: CHAR_MINUS, last: 1'b0, bad_base: 1'b0};
      pending_chars.push_back(rec);
    end
    foreach (digs[k]) begin
      rec = '{digit_char: digs[k], last: (k == digs.size() - 1), bad_base: 1'b0};
      pending_chars.push_back(rec);
    end
  endtask

  // Queue the expectation of an accepted request, typed in or predicted.
  task automatic push_expected(input row_kind_e kind, input string text, input logic act,
                               input logic [VW-1:0] val, input logic [5:0] b);
    char_rec_t rec;
    case (kind)
      ROW_TEXT: begin
        for (int k = 0; k < text.len(); k++) begin
          rec = '{digit_char: 7'(text[k]), last: (k == text.len() - 1), bad_base: 1'b0};
          pending_chars.push_back(rec);
        end
      end
      ROW_ERROR: begin
        rec = '{digit_char: CHAR_NONE, last: 1'b1, bad_base: 1'b1};
        pending_chars.push_back(rec);
      end
      default: predict_digits(act, val, b);
    endcase
  endtask

  // Drive one request in bursts with random gaps and hold it until accepted.
  task automatic send_request(input logic act, input logic [VW-1:0] val, input logic [5:0] b,
                              input row_kind_e kind, input string text);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 1500) : $urandom_range(1, 30);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    item_valid <= 1'b1;
    action <= act;
    value <= val;
    base <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    push_expected(kind, text, act, val, b);
  endtask

  task automatic add_row(input logic act, input logic [VW-1:0] val, input logic [5:0] b,
                         input row_kind_e kind, input string text);
    dir_act.push_back(act);
    dir_val.push_back(val);
    dir_base.push_back(b);
    dir_kind.push_back(kind);
    dir_text.push_back(text);
  endtask

  // Receiver stall pattern: free-running stretches of no stall, coin flips, or solid stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_left = (stall_mode == STALL_SOLID) ? $urandom_range(1, 12) : $urandom_range(4, 80);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:   char_stall <= 1'b0;
      STALL_RANDOM: char_stall <= ($urandom_range(0, 1) == 1);
      default:      char_stall <= 1'b1;
    endcase
  end

  // Compare each accepted character with the oldest expectation.
  always @(posedge clk) begin
    char_rec_t want;
    if (!rst && char_valid && !char_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("character with nothing pending, digit_char", digit_char, 0);
      end else begin
        want = pending_chars.pop_front();
        if (digit_char !== want.digit_char) begin
          report_mismatch("digit_char", digit_char, want.digit_char);
        end
        if (last !== want.last) begin
          report_mismatch("last", last, want.last);
        end
        if (bad_base !== want.bad_base) begin
          report_mismatch("bad_base", bad_base, want.bad_base);
        end
      end
    end
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (char_valid && !char_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("integer_to_radix_digits_core_tb failed");
    $finish;
  end

  // Main sequence: reset, directed table, random requests, drain.
  initial begin
    logic          act;
    logic [VW-1:0] val;
    logic [5:0]    b;
    int            pick;

    // Bad radices on both sides of the valid range.
    add_row(ACT_UNSIGNED, 32'h0000_0000, 6'd0,  ROW_ERROR, "");
    add_row(ACT_SIGNED,   32'hFFFF_FFFF, 6'd1,  ROW_ERROR, "");
    add_row(ACT_UNSIGNED, 32'h1234_5678, 6'd37, ROW_ERROR, "");
    add_row(ACT_SIGNED,   32'h8000_0000, 6'd63, ROW_ERROR, "");
    // Zero gives a single character.
    add_row(ACT_UNSIGNED, 32'h0000_0000, 6'd10, ROW_TEXT, "0");
    add_row(ACT_SIGNED,   32'h0000_0000, 6'd2,  ROW_TEXT, "0");
    add_row(ACT_UNSIGNED, 32'h0000_0000, 6'd36, ROW_TEXT, "0");
    // Extremes of the value.
    add_row(ACT_UNSIGNED, 32'hFFFF_FFFF, 6'd2,  ROW_TEXT, "11111111111111111111111111111111");
    add_row(ACT_UNSIGNED, 32'hFFFF_FFFF, 6'd16, ROW_TEXT, "FFFFFFFF");
    add_row(ACT_UNSIGNED, 32'hFFFF_FFFF, 6'd10, ROW_TEXT, "4294967295");
    // Signed mode outside base 10 converts the raw bits.
    add_row(ACT_SIGNED,   32'hFFFF_FFFF, 6'd16, ROW_TEXT, "FFFFFFFF");
    add_row(ACT_SIGNED,   32'h8000_0000, 6'd16, ROW_TEXT, "80000000");
    // Signed decimal, including the most negative value.
    add_row(ACT_SIGNED,   32'h8000_0000, 6'd10, ROW_TEXT, "-2147483648");
    add_row(ACT_SIGNED,   32'hFFFF_FFFF, 6'd10, ROW_TEXT, "-1");
    add_row(ACT_SIGNED,   32'h7FFF_FFFF, 6'd10, ROW_TEXT, "2147483647");
    add_row(ACT_UNSIGNED, 32'h8000_0000, 6'd10, ROW_TEXT, "2147483648");
    // Letter digits and single digits.
    add_row(ACT_UNSIGNED, 32'd35, 6'd36, ROW_TEXT, "Z");
    add_row(ACT_UNSIGNED, 32'd10, 6'd36, ROW_TEXT, "A");
    add_row(ACT_SIGNED,   32'd1,  6'd2,  ROW_TEXT, "1");
    // Remaining rows go through the predictor.
    add_row(ACT_SIGNED,   32'h8000_0000, 6'd2,  ROW_PREDICTED, "");
    add_row(ACT_UNSIGNED, 32'hFFFF_FFFF, 6'd36, ROW_PREDICTED, "");
    add_row(ACT_SIGNED,   32'hDEAD_BEEF, 6'd3,  ROW_PREDICTED, "");
    add_row(ACT_SIGNED,   32'hFFFF_FFF6, 6'd10, ROW_PREDICTED, "");
    add_row(ACT_UNSIGNED, 32'hA5A5_A5A5, 6'd7,  ROW_PREDICTED, "");

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < dir_act.size(); i++) begin
      send_request(dir_act[i], dir_val[i], dir_base[i], dir_kind[i], dir_text[i]);
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      act = 1'($urandom_range(0, 1));
      // Value mix: full random, small, sign edges, powers of two, small negatives.
      case ($urandom_range(0, 9))
        4: val = $urandom_range(0, 40);
        5: begin
          pick = $urandom_range(0, 3);
          val = (pick == 0) ? 32'hFFFF_FFFF : (pick == 1) ? 32'h0 :
                (pick == 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        6: val = (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
        7: val = -32'($urandom_range(1, 1000));
        default: val = $urandom;
      endcase
      // Base mix: mostly valid radices, a tenth bad ones.
      case ($urandom_range(0, 9))
        0: begin
          pick = $urandom_range(0, 28);
          b = (pick < 2) ? 6'(pick) : 6'(37 + pick - 2);
        end
        1: b = 6'd2;
        2: b = DEC_RADIX;
        3: b = ($urandom_range(0, 1) == 1) ? 6'd16 : RADIX_MAX;
        default: b = 6'($urandom_range(2, 36));
      endcase
      send_request(act, val, b, ROW_PREDICTED, "");
    end

    item_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("integer_to_radix_digits_core_tb passed");
    end else begin
      $display("integer_to_radix_digits_core_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
design/itrd_pkg.sv
design/itrd_divider.sv
design/integer_to_radix_digits_core.sv
dv/integer_to_radix_digits_core_tb.sv
